[rtl/kdrr_pkg.sv]
// shared types and constants for the key debounce and rollover report block
`timescale 1ns / 1ps

package kdrr_pkg;

  localparam int KEY_W          = 7;
  localparam int CODE_W         = 8;
  localparam int SLOT_COUNT     = 6;
  localparam int KEY_COUNT_DEF  = 128;
  localparam int LIST_DEPTH_DEF = 6;

  localparam logic [CODE_W-1:0] COMBO_RESET     = 8'd34;
  localparam logic [CODE_W-1:0] PRESS_PATTERN   = 8'h7F;
  localparam logic [CODE_W-1:0] RELEASE_PATTERN = 8'h80;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LAYOUT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key_index;
    logic              sample_bit;
    logic [CODE_W-1:0] layout_code;
    logic              layout_is_modifier;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] slot0_code;
    logic [CODE_W-1:0] slot1_code;
    logic [CODE_W-1:0] slot2_code;
    logic [CODE_W-1:0] slot3_code;
    logic [CODE_W-1:0] slot4_code;
    logic [CODE_W-1:0] slot5_code;
    logic [CODE_W-1:0] modifier_bits;
    logic              bootloader_request;
  } out_t;

  typedef struct packed {
    logic              is_mod;
    logic [CODE_W-1:0] code;
  } layout_t;

endpackage

[rtl/key_debounce_rollover_report.sv]
// top level: per-key debounce history, modifier byte, rollover list and report output
`timescale 1ns / 1ps

// Takes one item per cycle: either a layout write (keycode and modifier flag
// for one key) or one raw switch sample for one key. A sample whose debounced
// history turns into a press or a release produces one report item, registered
// in stage one and then the output register: six keycodes newest first (0 for an empty
// slot), the modifier byte and a bootloader request flag that is high when
// the modifier byte equals the combo register. Items are accepted
// every cycle; in_ready falls only while a report is pending and out_ready is
// low. The pace is set by the read-modify-write of the per-key history and
// layout memories (one read and one write port each, read data registered,
// the previous item's write forwarded). Keys at or above KEY_COUNT are taken
// and ignored. History resets to zero through per-key valid bits; a key's
// layout must be written before that key is pressed. cfg writes are always
// ready and belong in idle periods.
module key_debounce_rollover_report #(
  parameter int KEY_COUNT  = kdrr_pkg::KEY_COUNT_DEF,
  parameter int LIST_DEPTH = kdrr_pkg::LIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kdrr_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kdrr_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kdrr_pkg::CODE_W-1:0] cfg_data
);

  localparam int HIST_DEPTH = (KEY_COUNT < 128) ? KEY_COUNT : 128;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int KEY_W      = kdrr_pkg::KEY_W;
  localparam int CODE_W     = kdrr_pkg::CODE_W;
  localparam int SLOTS      = kdrr_pkg::SLOT_COUNT;

  // config register
  logic [CODE_W-1:0] combo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      combo <= kdrr_pkg::COMBO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      combo <= cfg_data;
    end
  end

  // input stage
  logic              in_fire;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;

  logic              s1_valid;
  kdrr_pkg::in_t     s1_item;
  logic [ADDR_W-1:0] s1_addr;
  logic [CODE_W-1:0] s1_hist_rd;
  logic              s1_hist_ok;
  logic              s1_hfwd_hit;
  logic [CODE_W-1:0] s1_hfwd_val;
  kdrr_pkg::layout_t s1_lay_rd;
  logic              s1_lfwd_hit;
  kdrr_pkg::layout_t s1_lfwd_val;

  logic              s1_advance;
  logic              s1_fire;
  logic              s1_is_sample;
  logic              s1_is_layout;

  // stores
  logic [CODE_W-1:0] hist_mem [HIST_DEPTH];
  kdrr_pkg::layout_t lay_mem  [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_valid;

  // stage one logic
  logic [CODE_W-1:0] hist_old;
  logic [CODE_W-1:0] hist_cmp;
  logic [CODE_W-1:0] hist_new;
  kdrr_pkg::layout_t lay_eff;
  logic              press;
  logic              release_hit;
  logic              s1_emit;

  // rollover list
  logic [LIST_DEPTH-1:0] list_valid;
  logic [KEY_W-1:0]      list_key  [LIST_DEPTH];
  logic [CODE_W-1:0]     list_code [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] list_valid_next;
  logic [KEY_W-1:0]      list_key_next  [LIST_DEPTH];
  logic [CODE_W-1:0]     list_code_next [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] remove_at;

  logic [CODE_W-1:0] modifier;
  logic [CODE_W-1:0] modifier_next;
  logic [CODE_W-1:0] slot_code [SLOTS];
  kdrr_pkg::out_t    report;

  assign in_fire  = in_valid && in_ready;
  assign in_range = 8'(in_data.key_index) < 8'(KEY_COUNT);
  assign in_addr  = in_data.key_index[ADDR_W-1:0];

  assign s1_is_sample = s1_item.kind == kdrr_pkg::KIND_SAMPLE;
  assign s1_is_layout = s1_item.kind == kdrr_pkg::KIND_LAYOUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_fire && in_range;
    end
  end

  // read side, plus forwarding of the write the current item makes at this edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item     <= in_data;
      s1_addr     <= in_addr;
      s1_hist_rd  <= hist_mem[in_addr];
      s1_hist_ok  <= hist_valid[in_addr];
      s1_lay_rd   <= lay_mem[in_addr];
      s1_hfwd_hit <= s1_fire && s1_is_sample && (s1_item.key_index == in_data.key_index);
      s1_hfwd_val <= hist_new;
      s1_lfwd_hit <= s1_fire && s1_is_layout && (s1_item.key_index == in_data.key_index);
      s1_lfwd_val <= '{is_mod: s1_item.layout_is_modifier, code: s1_item.layout_code};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_sample) begin
      hist_mem[s1_addr] <= hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_layout) begin
      lay_mem[s1_addr] <= '{is_mod: s1_item.layout_is_modifier, code: s1_item.layout_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (s1_fire && s1_is_sample) begin
      hist_valid[s1_addr] <= 1'b1;
    end
  end

  always_comb begin
    if (s1_hfwd_hit) begin
      hist_old = s1_hfwd_val;
    end else if (s1_hist_ok) begin
      hist_old = s1_hist_rd;
    end else begin
      hist_old = '0;
    end
    lay_eff     = s1_lfwd_hit ? s1_lfwd_val : s1_lay_rd;
    hist_cmp    = {hist_old[CODE_W-1:1], s1_item.sample_bit};
    hist_new    = {hist_cmp[CODE_W-2:0], hist_cmp[0]};
    press       = hist_cmp == kdrr_pkg::PRESS_PATTERN;
    release_hit = hist_cmp == kdrr_pkg::RELEASE_PATTERN;
  end

  assign s1_emit    = s1_valid && s1_is_sample && (press || release_hit);
  assign s1_advance = !s1_valid || !s1_emit || !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = s1_advance;

  // list and modifier update
  always_comb begin
    logic run;
    run             = 1'b0;
    list_valid_next = list_valid;
    list_key_next   = list_key;
    list_code_next  = list_code;
    modifier_next   = modifier;
    remove_at       = '0;
    for (int s = 0; s < LIST_DEPTH; s++) begin
      run          = run || (list_valid[s] && (list_key[s] == s1_item.key_index));
      remove_at[s] = run;
    end
    if (s1_fire && s1_is_layout) begin
      // keep listed codes in step with a rewritten layout entry
      for (int s = 0; s < LIST_DEPTH; s++) begin
        if (list_valid[s] && (list_key[s] == s1_item.key_index)) begin
          list_code_next[s] = s1_item.layout_code;
        end
      end
    end else if (s1_fire && s1_emit && lay_eff.is_mod) begin
      if (press) begin
        modifier_next = modifier | lay_eff.code;
      end else begin
        modifier_next = modifier & ~lay_eff.code;
      end
    end else if (s1_fire && s1_emit && press) begin
      for (int s = LIST_DEPTH - 1; s > 0; s--) begin
        list_valid_next[s] = list_valid[s-1];
        list_key_next[s]   = list_key[s-1];
        list_code_next[s]  = list_code[s-1];
      end
      list_valid_next[0] = 1'b1;
      list_key_next[0]   = s1_item.key_index;
      list_code_next[0]  = lay_eff.code;
    end else if (s1_fire && s1_emit) begin
      // first match and everything after it closes up by one
      for (int s = 0; s < LIST_DEPTH - 1; s++) begin
        if (remove_at[s]) begin
          list_valid_next[s] = list_valid[s+1];
          list_key_next[s]   = list_key[s+1];
          list_code_next[s]  = list_code[s+1];
        end
      end
      if (remove_at[LIST_DEPTH-1]) begin
        list_valid_next[LIST_DEPTH-1] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_valid <= '0;
      modifier   <= '0;
    end else begin
      list_valid <= list_valid_next;
      modifier   <= modifier_next;
    end
  end

  always_ff @(posedge clk) begin
    list_key  <= list_key_next;
    list_code <= list_code_next;
  end

  // report assembly
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    if (g < LIST_DEPTH) begin : g_live
      assign slot_code[g] = list_valid_next[g] ? list_code_next[g] : '0;
    end else begin : g_empty
      assign slot_code[g] = '0;
    end
  end

  always_comb begin
    report.slot0_code         = slot_code[0];
    report.slot1_code         = slot_code[1];
    report.slot2_code         = slot_code[2];
    report.slot3_code         = slot_code[3];
    report.slot4_code         = slot_code[4];
    report.slot5_code         = slot_code[5];
    report.modifier_bits      = modifier_next;
    report.bootloader_request = modifier_next == combo;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_data <= report;
    end
  end

`ifndef SYNTHESIS
  // a stall only comes from a pending report that cannot leave
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_emit && out_valid && !out_ready))
    else $error("input stalled without a blocked report");

  // listed entries always sit packed at the front
  assert property (@(posedge clk) disable iff (rst)
    (list_valid & (list_valid + LIST_DEPTH'(1))) == '0)
    else $error("rollover list has a gap");

  // a plain key press lands in the front slot
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_emit && press && !lay_eff.is_mod) |=>
      (list_valid[0] && (list_key[0] == $past(s1_item.key_index))))
    else $error("pressed key missing from front slot");

  // a modifier press leaves its bits set in the report
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_emit && press && lay_eff.is_mod) |=>
      (out_valid && ((out_data.modifier_bits & $past(lay_eff.code)) == $past(lay_eff.code))))
    else $error("modifier press not reported");
`endif

endmodule
